/* design/c3f_pkg.sv */
// ----------------------------------------------------------------------------
// c3f_pkg
// shared constants, configuration and job types of the 3x3 rgb filter
// ----------------------------------------------------------------------------
package c3f_pkg;

   // line store geometry
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);

   // fixed register widths
   localparam int KR_W       = 24;
   localparam int OFF_W      = 9;
   localparam int DIV_W      = 10;
   localparam int FW_W       = 11;
   localparam int FH_W       = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int EFF_W      = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;

   // datapath widths: |sum| <= 9 * 255 * 128 < 2**19
   localparam int ACC_W = 20;
   localparam int MAG_W = 19;
   localparam int CNT_W = $clog2(MAG_W);

   // job queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KTOP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KMID   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KBOT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVSR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 3'd6;

   typedef struct packed {
      logic [KR_W-1:0]         k_top;
      logic [KR_W-1:0]         k_mid;
      logic [KR_W-1:0]         k_bot;
      logic signed [OFF_W-1:0] offset;
      logic [DIV_W-1:0]        divisor;
      logic [FW_W-1:0]         width;
      logic [FH_W-1:0]         height;
   } cfg_type;

   // one output pixel to compute: window pixel (row i, column j) at i*3+j
   typedef struct packed {
      logic [8:0][31:0] pix;
      logic             done;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* design/c3f_queue.sv */
// ----------------------------------------------------------------------------
// c3f_queue
// short job queue between the window front end and the arithmetic back end
// ----------------------------------------------------------------------------
module c3f_queue
   import c3f_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  job_type   push_job,
   input  logic      pop,
   output job_type   head_job,
   output qstat_type stat
);

   job_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign stat.full  = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   // pointer and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* design/c3f_front.sv */
// ----------------------------------------------------------------------------
// c3f_front
// takes pixels, keeps line stores and window, queues the output jobs
// ----------------------------------------------------------------------------
module c3f_front
   import c3f_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic [7:0] req_alpha,
   input  qstat_type qstat,
   output logic      push,
   output job_type   push_job
);

   typedef enum logic [1:0] {FR_IDLE, FR_BUILD, FR_EMIT} fr_state_type;

   fr_state_type      state_ff;
   logic [COL_W-1:0]  col_ff, x_ff, x_cur;
   logic [FH_W-1:0]   row_ff;
   logic [31:0]       pix_ff;
   logic              xge1_ff, xis1_ff, y0_ff, y1_ff, lastc_ff, lastr_ff;
   logic [31:0]       old_rd_ff, new_rd_ff;
   logic [31:0]       win_ff [6];
   logic [31:0]       cols_ff [3][3];
   logic [1:0]        k_ff;
   logic [31:0]       older_mem [MAX_WIDTH];
   logic [31:0]       newer_mem [MAX_WIDTH];

   logic              accept, mem_wr, cond;
   logic [EFF_W-1:0]  weff;
   logic [FH_W-1:0]   heff;
   logic              lastc, lastr;
   logic [1:0]        lk, ck, tr, mr;
   logic [1:0]        ks [3];
   logic [1:0]        rs [3];

   assign req_ready = (state_ff == FR_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign mem_wr    = (state_ff == FR_BUILD);

   // effective geometry and position
   always_comb begin
      weff = EFF_W'(cfg.width);
      if (weff == '0) begin
         weff = EFF_W'(1);
      end else if (weff > EFF_W'(MAX_WIDTH)) begin
         weff = EFF_W'(MAX_WIDTH);
      end
      heff = (cfg.height == '0) ? FH_W'(1) : cfg.height;
      x_cur = ((COL_W+1)'(col_ff) >= (COL_W+1)'(MAX_WIDTH)) ? '0 : col_ff;
      lastc = (EFF_W'(x_cur) + EFF_W'(1)) >= weff;
      lastr = ({1'b0, row_ff} + (FH_W+1)'(1)) >= {1'b0, heff};
   end

   // window selection for the current job slot
   always_comb begin
      lk   = '0;
      ck   = '0;
      tr   = '0;
      mr   = '0;
      cond = 1'b0;
      unique case (k_ff)
         2'd0: begin
            lk = xis1_ff ? 2'd1 : 2'd2; ck = 2'd1;
            tr = y1_ff ? 2'd1 : 2'd0;   mr = 2'd1;
            cond = xge1_ff && !y0_ff;
         end
         2'd1: begin
            lk = xis1_ff ? 2'd1 : 2'd2; ck = 2'd1;
            tr = y0_ff ? 2'd2 : 2'd1;   mr = 2'd2;
            cond = xge1_ff && lastr_ff;
         end
         2'd2: begin
            lk = xge1_ff ? 2'd1 : 2'd0; ck = 2'd0;
            tr = y1_ff ? 2'd1 : 2'd0;   mr = 2'd1;
            cond = lastc_ff && !y0_ff;
         end
         default: begin
            lk = xge1_ff ? 2'd1 : 2'd0; ck = 2'd0;
            tr = y0_ff ? 2'd2 : 2'd1;   mr = 2'd2;
            cond = lastc_ff && lastr_ff;
         end
      endcase
      ks[0] = lk; ks[1] = ck; ks[2] = 2'd0;
      rs[0] = tr; rs[1] = mr; rs[2] = 2'd2;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            push_job.pix[i*3+j] = cols_ff[ks[j]][rs[i]];
         end
      end
      push_job.done = (k_ff == 2'd3);
   end

   assign push = (state_ff == FR_EMIT) && cond && !qstat.full;

   // sequencer, counters and window
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         k_ff     <= '0;
      end else begin
         unique case (state_ff)
            FR_IDLE: begin
               if (accept) begin
                  pix_ff   <= {req_alpha, req_blue, req_green, req_red};
                  x_ff     <= x_cur;
                  xge1_ff  <= (x_cur != '0);
                  xis1_ff  <= (x_cur == COL_W'(1));
                  y0_ff    <= (row_ff == '0);
                  y1_ff    <= (row_ff == FH_W'(1));
                  lastc_ff <= lastc;
                  lastr_ff <= lastr;
                  if (lastc) begin
                     col_ff <= '0;
                     row_ff <= lastr ? '0 : row_ff + 1'b1;
                  end else begin
                     col_ff <= x_cur + 1'b1;
                  end
                  state_ff <= FR_BUILD;
               end
            end
            FR_BUILD: begin
               cols_ff[0][0] <= old_rd_ff;
               cols_ff[0][1] <= new_rd_ff;
               cols_ff[0][2] <= pix_ff;
               for (int r = 0; r < 3; r++) begin
                  cols_ff[1][r] <= win_ff[r];
                  cols_ff[2][r] <= win_ff[3+r];
                  win_ff[3+r]   <= win_ff[r];
               end
               win_ff[0] <= old_rd_ff;
               win_ff[1] <= new_rd_ff;
               win_ff[2] <= pix_ff;
               k_ff      <= '0;
               state_ff  <= FR_EMIT;
            end
            FR_EMIT: begin
               if (!cond || !qstat.full) begin
                  k_ff <= k_ff + 1'b1;
                  if (k_ff == 2'd3) begin
                     state_ff <= FR_IDLE;
                  end
               end
            end
            default: state_ff <= FR_IDLE;
         endcase
      end
   end

   // line stores: read on accept, written back in the cycle after
   always_ff @(posedge clock) begin
      if (accept) begin
         old_rd_ff <= older_mem[x_cur];
         new_rd_ff <= newer_mem[x_cur];
      end
      if (mem_wr) begin
         older_mem[x_ff] <= new_rd_ff;
         newer_mem[x_ff] <= pix_ff;
      end
   end

endmodule

/* design/c3f_back.sv */
// ----------------------------------------------------------------------------
// c3f_back
// per job: kernel multiply-accumulate, division, offset, clamp, result register
// ----------------------------------------------------------------------------
module c3f_back
   import c3f_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  qstat_type  qstat,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic [7:0] rsp_alpha,
   output logic       rsp_frame_done
);

   typedef enum logic [2:0] {BK_IDLE, BK_MAC, BK_SIGN, BK_DIV, BK_FIN} bk_state_type;

   bk_state_type             state_ff;
   job_type                  job_ff;
   logic [1:0]               i_ff, j_ff;
   logic signed [ACC_W-1:0]  acc_ff [3];
   logic                     neg_ff [3];
   logic [MAG_W-1:0]         dq_ff [3];
   logic [DIV_W-1:0]         rem_ff [3];
   logic [CNT_W-1:0]         cnt_ff;
   logic                     rsp_valid_ff;
   logic [7:0]               out_ff [3];
   logic [7:0]               alpha_ff;
   logic                     done_ff;

   logic [KR_W-1:0]          krow;
   logic signed [7:0]        w;
   logic [3:0]               idx;
   logic [31:0]              p;
   logic signed [16:0]       prod [3];
   logic [DIV_W-1:0]         dv;
   logic [DIV_W:0]           trial [3];
   logic                     qbit [3];
   logic signed [ACC_W:0]    v [3];
   logic [7:0]               clamp [3];
   logic                     out_free;

   assign pop            = (state_ff == BK_IDLE) && !qstat.empty;
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = out_ff[0];
   assign rsp_green      = out_ff[1];
   assign rsp_blue       = out_ff[2];
   assign rsp_alpha      = alpha_ff;
   assign rsp_frame_done = done_ff;

   // one kernel tap for all three channels
   always_comb begin
      unique case (i_ff)
         2'd0:    krow = cfg.k_top;
         2'd1:    krow = cfg.k_mid;
         default: krow = cfg.k_bot;
      endcase
      w   = krow[8*j_ff +: 8];
      idx = {2'b00, i_ff} * 4'd3 + {2'b00, j_ff};
      p   = job_ff.pix[idx];
      for (int c = 0; c < 3; c++) begin
         prod[c] = $signed({1'b0, p[8*c +: 8]}) * w;
      end
   end

   // divider step and final scaling per channel
   always_comb begin
      dv = (cfg.divisor == '0) ? DIV_W'(1) : cfg.divisor;
      for (int c = 0; c < 3; c++) begin
         trial[c] = {rem_ff[c], dq_ff[c][MAG_W-1]};
         qbit[c]  = (trial[c] >= {1'b0, dv});
         v[c]     = (neg_ff[c] ? -$signed({2'b00, dq_ff[c]}) : $signed({2'b00, dq_ff[c]}))
                    + (ACC_W+1)'(cfg.offset);
         if (v[c] < 0) begin
            clamp[c] = 8'd0;
         end else if (v[c] > (ACC_W+1)'(255)) begin
            clamp[c] = 8'd255;
         end else begin
            clamp[c] = v[c][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         cnt_ff       <= '0;
      end else begin
         // result valid: set on a new result, cleared when taken
         if ((state_ff == BK_FIN) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            BK_IDLE: begin
               if (pop) begin
                  job_ff <= head_job;
                  for (int c = 0; c < 3; c++) begin
                     acc_ff[c] <= '0;
                  end
                  i_ff     <= '0;
                  j_ff     <= '0;
                  state_ff <= BK_MAC;
               end
            end
            // nine taps, row by row
            BK_MAC: begin
               for (int c = 0; c < 3; c++) begin
                  acc_ff[c] <= acc_ff[c] + ACC_W'(prod[c]);
               end
               if (j_ff == 2'd2) begin
                  j_ff <= '0;
                  i_ff <= i_ff + 1'b1;
                  if (i_ff == 2'd2) begin
                     state_ff <= BK_SIGN;
                  end
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            BK_SIGN: begin
               for (int c = 0; c < 3; c++) begin
                  neg_ff[c] <= acc_ff[c][ACC_W-1];
                  dq_ff[c]  <= acc_ff[c][ACC_W-1] ? MAG_W'(-acc_ff[c]) : MAG_W'(acc_ff[c]);
                  rem_ff[c] <= '0;
               end
               cnt_ff   <= '0;
               state_ff <= BK_DIV;
            end
            // restoring division of the magnitude, one quotient bit a cycle
            BK_DIV: begin
               for (int c = 0; c < 3; c++) begin
                  rem_ff[c] <= qbit[c] ? DIV_W'(trial[c] - {1'b0, dv}) : trial[c][DIV_W-1:0];
                  dq_ff[c]  <= {dq_ff[c][MAG_W-2:0], qbit[c]};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(MAG_W - 1)) begin
                  state_ff <= BK_FIN;
               end
            end
            BK_FIN: begin
               if (out_free) begin
                  for (int c = 0; c < 3; c++) begin
                     out_ff[c] <= clamp[c];
                  end
                  alpha_ff <= job_ff.pix[4][31:24];
                  done_ff  <= job_ff.done;
                  state_ff <= BK_IDLE;
               end
            end
            default: state_ff <= BK_IDLE;
         endcase
      end
   end

endmodule

/* design/conv3x3_rgb_filter_core.sv */
// ----------------------------------------------------------------------------
// conv3x3_rgb_filter_core
// 3x3 kernel filter over an rgba pixel stream with replicated edges
// ----------------------------------------------------------------------------
// pixels enter in raster order on req_* (valid/ready); filtered pixels leave on
// rsp_* (valid/ready), trailing the input by one row and one pixel, and the
// last input row also flushes the final output row; rsp_frame_done marks the
// bottom-right output. kernel, offset, divisor and frame size are written on
// csr_*; the user must write them only while the block is idle, which the block
// itself does not enforce.
// in the front end a pixel item passes through accept, window build and four
// output slots (0 to 4 of them queue a job), a slot waiting while the queue
// is full; the front end takes one item at a time.
// each output passes through the back end as queue pop, 9 multiply-accumulate
// steps (one kernel tap for all three channels a cycle), sign split, the
// bit-serial divider and result; the back end takes one job at a time.
// a 4-entry job queue decouples the two halves; when the receiver stalls the
// result register holds, then the queue fills, then req_ready drops.
// reset clears the counters, the queue and the control state and restores the
// register defaults; line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module conv3x3_rgb_filter_core
   import c3f_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_in_red,
   input  logic [7:0]            req_in_green,
   input  logic [7:0]            req_in_blue,
   input  logic [7:0]            req_in_alpha,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_red,
   output logic [7:0]            rsp_out_green,
   output logic [7:0]            rsp_out_blue,
   output logic [7:0]            rsp_out_alpha,
   output logic                  rsp_frame_done
);

   cfg_type   cfg_ff;
   qstat_type qstat;
   logic      push, pop;
   job_type   push_job, head_job;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.k_top   <= '0;
         cfg_ff.k_mid   <= KR_W'(256);
         cfg_ff.k_bot   <= '0;
         cfg_ff.offset  <= '0;
         cfg_ff.divisor <= DIV_W'(1);
         cfg_ff.width   <= FW_W'(1024);
         cfg_ff.height  <= FH_W'(768);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KTOP:   cfg_ff.k_top   <= csr_wdata[KR_W-1:0];
            CSR_KMID:   cfg_ff.k_mid   <= csr_wdata[KR_W-1:0];
            CSR_KBOT:   cfg_ff.k_bot   <= csr_wdata[KR_W-1:0];
            CSR_OFFSET: cfg_ff.offset  <= csr_wdata[OFF_W-1:0];
            CSR_DIVSR:  cfg_ff.divisor <= csr_wdata[DIV_W-1:0];
            CSR_WIDTH:  cfg_ff.width   <= csr_wdata[FW_W-1:0];
            CSR_HEIGHT: cfg_ff.height  <= csr_wdata[FH_W-1:0];
            default: ;
         endcase
      end
   end

   c3f_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_red   (req_in_red),
      .req_green (req_in_green),
      .req_blue  (req_in_blue),
      .req_alpha (req_in_alpha),
      .qstat     (qstat),
      .push      (push),
      .push_job  (push_job)
   );

   c3f_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (qstat)
   );

   c3f_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .qstat          (qstat),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_out_red),
      .rsp_green      (rsp_out_green),
      .rsp_blue       (rsp_out_blue),
      .rsp_alpha      (rsp_out_alpha),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

/* design/c3f_checker.sv */
// ----------------------------------------------------------------------------
// c3f_checker
// port-level checks of the filter core, bound to the top level
// ----------------------------------------------------------------------------
module c3f_checker
   import c3f_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  csr_wr_en,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [7:0]            req_in_red,
   input logic [7:0]            req_in_green,
   input logic [7:0]            req_in_blue,
   input logic [7:0]            req_in_alpha,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [7:0]            rsp_out_red,
   input logic [7:0]            rsp_out_green,
   input logic [7:0]            rsp_out_blue,
   input logic [7:0]            rsp_out_alpha,
   input logic                  rsp_frame_done
);

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // front end is busy for the cycle after it takes an item
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item taken on back-to-back cycles");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_red)
         && $stable(rsp_out_green) && $stable(rsp_out_blue)
         && $stable(rsp_out_alpha) && $stable(rsp_frame_done)))
      else $error("stalled result changed");

   // a waiting item holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_in_red)
         && $stable(req_in_green) && $stable(req_in_blue)
         && $stable(req_in_alpha)))
      else $error("waiting item changed");

   // register writes carry known index and data
   a_csr_known: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |-> !$isunknown({csr_index, csr_wdata}))
      else $error("register write with unknown bits");

endmodule

bind conv3x3_rgb_filter_core c3f_checker u_c3f_checker (.*);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// stimulus and checking for the 3x3 rgb filter core
// ----------------------------------------------------------------------------
// whole frames are streamed into the block, and a predictor in the testbench
// computes every filtered pixel. each output item is compared with the oldest
// pending prediction. the register settings only change between frames, once
// the block has drained. both handshakes idle at random, except for one frame
// that runs with no idling at all.
// ----------------------------------------------------------------------------
module tb;
   import c3f_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       done;
   } out_pixel_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_in_red;
   logic [7:0]            req_in_green;
   logic [7:0]            req_in_blue;
   logic [7:0]            req_in_alpha;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_out_red;
   logic [7:0]            rsp_out_green;
   logic [7:0]            rsp_out_blue;
   logic [7:0]            rsp_out_alpha;
   logic                  rsp_frame_done;

   conv3x3_rgb_filter_core DUT (.*);

   // predictor state: registers, line stores, window and position
   logic [KR_W-1:0]         k_top, k_mid, k_bot;
   logic signed [OFF_W-1:0] k_offset;
   logic [DIV_W-1:0]        k_divisor;
   logic [FW_W-1:0]         frame_w;
   logic [FH_W-1:0]         frame_h;
   logic [31:0]             older_line [MAX_WIDTH];
   logic [31:0]             newer_line [MAX_WIDTH];
   logic [31:0]             window [6];
   int                      col_pos, row_pos;

   out_pixel_type expected_pixels [$];
   bit  idle_on;
   int  errors, cycles, pixels_sent, pixels_checked, frames_sent;

   // clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // cycle counter and run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("timeout at %0t with %0d pixels pending", $time, expected_pixels.size());
         $display("Verification failed");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
   end

   // output checking
   always @(posedge clock) begin
      out_pixel_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha, rsp_frame_done};
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected item r%0d g%0d b%0d a%0d done %0b", $time,
                     got.red, got.green, got.blue, got.alpha, got.done);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected r%0d g%0d b%0d a%0d done %0b", $time,
                        want.red, want.green, want.blue, want.alpha, want.done);
               $display("%0t:          actual   r%0d g%0d b%0d a%0d done %0b", $time,
                        got.red, got.green, got.blue, got.alpha, got.done);
               errors++;
            end
         end
         pixels_checked++;
      end
   end

   // one filtered pixel from the window columns
   function automatic out_pixel_type filter_at(input logic [31:0] c [3][3], input int lk,
                                               input int ck, input int rk, input int tr,
                                               input int mr, input int br, input bit done);
      out_pixel_type o;
      int ks[3], rs[3], acc, v, w, dv;
      logic [KR_W-1:0] rows[3];
      logic [31:0] p;
      ks = '{lk, ck, rk};
      rs = '{tr, mr, br};
      rows = '{k_top, k_mid, k_bot};
      dv = k_divisor;
      if (dv == 0) dv = 1;
      for (int ch = 0; ch < 3; ch++) begin
         acc = 0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               p = c[ks[j]][rs[i]];
               w = $signed(rows[i][8*j +: 8]);
               acc += int'(p[8*ch +: 8]) * w;
            end
         end
         v = acc / dv + k_offset;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         case (ch)
            0: o.red = v[7:0];
            1: o.green = v[7:0];
            default: o.blue = v[7:0];
         endcase
      end
      p = c[ck][mr];
      o.alpha = p[31:24];
      o.done = done;
      return o;
   endfunction

   // advance the predictor by one accepted pixel
   task automatic predict_pixel(input logic [31:0] pix);
      int weff, heff, x, y, lk;
      logic [31:0] c [3][3];
      bit lastc, lastr;
      weff = frame_w;
      if (weff == 0) weff = 1;
      if (weff > MAX_WIDTH) weff = MAX_WIDTH;
      heff = frame_h;
      if (heff == 0) heff = 1;
      x = col_pos;
      if (x >= MAX_WIDTH) x = 0;
      y = row_pos;
      lastc = (x + 1 >= weff);
      lastr = (y + 1 >= heff);
      c[0][0] = older_line[x];
      c[0][1] = newer_line[x];
      c[0][2] = pix;
      for (int r = 0; r < 3; r++) begin
         c[1][r] = window[r];
         c[2][r] = window[3+r];
      end
      older_line[x] = newer_line[x];
      newer_line[x] = pix;
      for (int r = 0; r < 3; r++) begin
         window[3+r] = window[r];
         window[r] = c[0][r];
      end
      if (x >= 1) begin
         lk = (x == 1) ? 1 : 2;
         if (y >= 1)
            expected_pixels.push_back(filter_at(c, lk, 1, 0, (y == 1) ? 1 : 0, 1, 2, 0));
         if (lastr)
            expected_pixels.push_back(filter_at(c, lk, 1, 0, (y == 0) ? 2 : 1, 2, 2, 0));
      end
      if (lastc) begin
         lk = (x == 0) ? 0 : 1;
         if (y >= 1)
            expected_pixels.push_back(filter_at(c, lk, 0, 0, (y == 1) ? 1 : 0, 1, 2, 0));
         if (lastr)
            expected_pixels.push_back(filter_at(c, lk, 0, 0, (y == 0) ? 2 : 1, 2, 2, 1));
         col_pos = 0;
         row_pos = lastr ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
      end
   endtask

   // register write, mirrored into the predictor
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_KTOP:   k_top = data;
         CSR_KMID:   k_mid = data;
         CSR_KBOT:   k_bot = data;
         CSR_OFFSET: k_offset = data[OFF_W-1:0];
         CSR_DIVSR:  k_divisor = data[DIV_W-1:0];
         CSR_WIDTH:  frame_w = data[FW_W-1:0];
         CSR_HEIGHT: frame_h = data[FH_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_filter(input logic [23:0] kt, input logic [23:0] km,
                               input logic [23:0] kb, input int off, input int dv);
      write_reg(CSR_KTOP, kt);
      write_reg(CSR_KMID, km);
      write_reg(CSR_KBOT, kb);
      write_reg(CSR_OFFSET, CSR_DATA_W'(off));
      write_reg(CSR_DIVSR, CSR_DATA_W'(dv));
   endtask

   // send one pixel item; called at a falling edge, returns at a falling edge
   task automatic send_pixel(input logic [31:0] pix);
      if (idle_on && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_in_red   <= pix[7:0];
      req_in_green <= pix[15:8];
      req_in_blue  <= pix[23:16];
      req_in_alpha <= pix[31:24];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pixel(pix);
      pixels_sent++;
      @(negedge clock);
   endtask

   // wait until every predicted pixel has come out, then let the block settle
   task automatic drain;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // one whole frame; extreme picks channel values of 0 or 255 only
   task automatic send_frame(input int w, input int h, input int extreme_pct);
      logic [31:0] pix;
      write_reg(CSR_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_HEIGHT, CSR_DATA_W'(h));
      for (int n = 0; n < w * h; n++) begin
         pix = $urandom();
         if ($urandom_range(99) < extreme_pct)
            for (int b = 0; b < 4; b++) pix[8*b +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
         send_pixel(pix);
      end
      req_valid <= 1'b0;
      frames_sent++;
      drain();
   endtask

   // reset defaults: identity kernel, only the frame size written
   task automatic test_defaults;
      send_frame(1, 1, 0);
      send_frame(3, 2, 0);
   endtask

   // extreme kernels, offsets and divisors on extreme pixels
   task automatic test_extremes;
      write_filter(24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f, 255, 1);
      send_frame(2, 2, 100);
      write_filter(24'h808080, 24'h808080, 24'h808080, -255, 1023);
      send_frame(3, 3, 100);
      write_filter(24'h000000, 24'h000000, 24'h000000, 0, 1);
      send_frame(2, 1, 50);
   endtask

   // random settings and small frames, one frame with no idling
   task automatic test_random_frames;
      int w, h, target;
      target = pixels_sent + 120;
      for (int f = 0; pixels_sent < target; f++) begin
         write_filter(KR_W'($urandom()), KR_W'($urandom()), KR_W'($urandom()),
                      int'($urandom_range(510)) - 255,
                      ($urandom_range(3) == 0) ? int'($urandom_range(1, 1023))
                                               : int'($urandom_range(1, 40)));
         w = ($urandom_range(4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         idle_on = (f != 3);
         send_frame(w, h, 30);
      end
      idle_on = 1'b1;
   endtask

   // a wide single row and a tall narrow frame
   task automatic test_large_geometry;
      write_filter(24'h01fe01, 24'h02fc02, 24'hff01ff, -20, 7);
      send_frame(64, 1, 20);
      send_frame(1, 40, 20);
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_in_red = '0;
      req_in_green = '0;
      req_in_blue = '0;
      req_in_alpha = '0;
      rsp_ready = 1'b0;
      idle_on = 1'b1;
      errors = 0;
      cycles = 0;
      pixels_sent = 0;
      pixels_checked = 0;
      frames_sent = 0;
      // predictor reset state
      k_top = '0;
      k_mid = 24'd256;
      k_bot = '0;
      k_offset = '0;
      k_divisor = 10'd1;
      frame_w = 11'd1024;
      frame_h = 12'd768;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         older_line[i] = '0;
         newer_line[i] = '0;
      end
      for (int i = 0; i < 6; i++) window[i] = '0;
      col_pos = 0;
      row_pos = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_defaults();
      test_extremes();
      test_random_frames();
      test_large_geometry();

      $display("%0d frames of %0d pixels streamed, %0d filtered pixels checked",
               frames_sent, pixels_sent, pixels_checked);
      $display("kernels, offsets, divisors and frame sizes swept, including extremes");
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d pixels never seen", errors, expected_pixels.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* conv3x3_rgb_filter_core.f */
design/c3f_pkg.sv
design/c3f_queue.sv
design/c3f_front.sv
design/c3f_back.sv
design/conv3x3_rgb_filter_core.sv
design/c3f_checker.sv
sim/tb.sv
